>>> design/hrip_pkg.sv
// Shared types, constants and the hex digit decoder for the hex-record image parser.
// No dependencies.
`timescale 1ns / 1ps

package hrip_pkg;

   localparam int ADDR_BITS = 16;
   localparam int POS_BITS  = 17;
   localparam int LEFT_BITS = 9;

   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] PAD_RESET  = 8'hFF;

   typedef enum logic [3:0] {
      PH_COLON   = 4'd0,
      PH_CNT_HI  = 4'd1,
      PH_CNT_LO  = 4'd2,
      PH_ADDR0   = 4'd3,
      PH_ADDR1   = 4'd4,
      PH_ADDR2   = 4'd5,
      PH_ADDR3   = 4'd6,
      PH_TYPE_HI = 4'd7,
      PH_TYPE_LO = 4'd8,
      PH_DAT_HI  = 4'd9,
      PH_DAT_LO  = 4'd10,
      PH_DONE    = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_PAD  = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   // anything that is not 0-9, A-F or a-f decodes as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      begin
         t = 8'h00;
         if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
         end
         return t[3:0];
      end
   endfunction

endpackage

>>> design/hex_record_image_parser.sv
// Top level of the hex-record image parser: input register, record state machine,
// output register. Depends on hrip_pkg.
`timescale 1ns / 1ps

// Takes one ASCII character per item and emits at most one result per character: a data
// byte, a pad run covering an address gap (filled with the pad byte from the csr port,
// reset 0xFF) or the end of image with its length. One character is taken every cycle
// while the result side is not stalled; each item is held in the input register until the
// output register can take a result, which is then loaded into it. Throughput is bounded
// only by the single output register, which stalls the input when a result waits and
// rsp_stall is high. After an end-of-file record all further characters are dropped until
// reset.
module hex_record_image_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [16:0] rsp_position,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_run_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int AB = hrip_pkg::ADDR_BITS;
   localparam int PB = hrip_pkg::POS_BITS;
   localparam int LB = hrip_pkg::LEFT_BITS;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;

   // record state
   hrip_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    count_ff, count_in;
   logic [AB-1:0] addr_ff, addr_in;
   logic [PB-1:0] fill_ff, fill_in;
   logic [3:0]    nibble_ff, nibble_in;
   logic [LB-1:0] left_ff, left_in;
   logic [7:0]    pad_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    kind_ff;
   logic [PB-1:0] pos_ff;
   logic [7:0]    val_ff;
   logic [15:0]   len_ff;

   logic          advance, fire, has_res;
   logic [1:0]    res_kind;
   logic [PB-1:0] res_pos;
   logic [7:0]    res_val;
   logic [15:0]   res_len;
   logic [3:0]    digit;
   logic [7:0]    byte_now;
   logic [PB-1:0] addr_ext, end_pos, fill_new, span;
   logic [LB-1:0] left_dec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_position   = pos_ff;
   assign rsp_byte_value = val_ff;
   assign rsp_run_length = len_ff;

   assign digit    = hrip_pkg::hex_value(s1_char_ff);
   assign byte_now = {nibble_ff, digit};
   assign addr_ext = {{(PB-AB){1'b0}}, addr_ff};
   assign fill_new = (addr_ext > fill_ff) ? addr_ext : fill_ff;
   assign end_pos  = addr_ext + {{(PB-8){1'b0}}, count_ff};
   assign span     = end_pos - fill_new;
   assign left_dec = left_ff - {{(LB-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      fill_in   = fill_ff;
      nibble_in = nibble_ff;
      left_in   = left_ff;
      has_res   = 1'b0;
      res_kind  = hrip_pkg::KIND_DATA;
      res_pos   = fill_ff;
      res_val   = 8'h00;
      res_len   = 16'h0000;
      case (phase_ff)
         hrip_pkg::PH_COLON: begin
            if (s1_char_ff == hrip_pkg::COLON_CHAR) phase_in = hrip_pkg::PH_CNT_HI;
         end
         hrip_pkg::PH_CNT_HI: begin
            nibble_in = digit;
            phase_in  = hrip_pkg::PH_CNT_LO;
         end
         hrip_pkg::PH_CNT_LO: begin
            count_in = byte_now;
            if (byte_now == 8'h00) begin
               phase_in = hrip_pkg::PH_DONE;
               has_res  = 1'b1;
               res_kind = hrip_pkg::KIND_END;
            end else begin
               addr_in  = '0;
               phase_in = hrip_pkg::PH_ADDR0;
            end
         end
         hrip_pkg::PH_ADDR0, hrip_pkg::PH_ADDR1, hrip_pkg::PH_ADDR2: begin
            addr_in  = {addr_ff[AB-5:0], digit};
            phase_in = hrip_pkg::phase_type'(phase_ff + 4'd1);
         end
         hrip_pkg::PH_ADDR3: begin
            addr_in  = {addr_ff[AB-5:0], digit};
            phase_in = hrip_pkg::PH_TYPE_HI;
         end
         hrip_pkg::PH_TYPE_HI: begin
            phase_in = hrip_pkg::PH_TYPE_LO;
         end
         hrip_pkg::PH_TYPE_LO: begin
            if (addr_ext > fill_ff) begin
               has_res  = 1'b1;
               res_kind = hrip_pkg::KIND_PAD;
               res_val  = pad_ff;
               res_len  = addr_ff - fill_ff[AB-1:0];
            end
            fill_in = fill_new;
            // span never exceeds the byte count when the record reaches past the fill
            if (end_pos > fill_new) begin
               left_in  = span[LB-1:0];
               phase_in = hrip_pkg::PH_DAT_HI;
            end else begin
               left_in  = '0;
               phase_in = hrip_pkg::PH_COLON;
            end
         end
         hrip_pkg::PH_DAT_HI: begin
            nibble_in = digit;
            phase_in  = hrip_pkg::PH_DAT_LO;
         end
         hrip_pkg::PH_DAT_LO: begin
            has_res  = 1'b1;
            res_kind = hrip_pkg::KIND_DATA;
            res_val  = byte_now;
            fill_in  = fill_ff + {{(PB-1){1'b0}}, 1'b1};
            left_in  = left_dec;
            phase_in = (left_dec == '0) ? hrip_pkg::PH_COLON : hrip_pkg::PH_DAT_HI;
         end
         hrip_pkg::PH_DONE: begin
            phase_in = hrip_pkg::PH_DONE;
         end
         default: begin
            phase_in = hrip_pkg::PH_COLON;
         end
      endcase
   end

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? (fire && has_res) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= hrip_pkg::PH_COLON;
         count_ff     <= '0;
         addr_ff      <= '0;
         fill_ff      <= '0;
         nibble_ff    <= '0;
         left_ff      <= '0;
         pad_ff       <= hrip_pkg::PAD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            addr_ff   <= addr_in;
            fill_ff   <= fill_in;
            nibble_ff <= nibble_in;
            left_ff   <= left_in;
         end
         if (csr_valid && csr_ready) pad_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) s1_char_ff <= req_char_in;
      if (fire && has_res) begin
         kind_ff <= res_kind;
         pos_ff  <= res_pos;
         val_ff  <= res_val;
         len_ff  <= res_len;
      end
   end

   // an end-of-image result always leaves the parser in its final state
   a_end_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == hrip_pkg::KIND_END |-> phase_ff == hrip_pkg::PH_DONE)
      else $error("end of image reported but parser not finished");

   // a pad run is only produced for a real gap
   a_pad_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == hrip_pkg::KIND_PAD |-> len_ff != 16'h0000)
      else $error("pad run with zero length");

   // once finished, no further result is loaded
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hrip_pkg::PH_DONE && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result produced after end of image");

endmodule
